### rtl/srt_euler_transform_matrix_macros.svh
`ifndef SRT_EULER_TRANSFORM_MATRIX_MACROS_SVH
`define SRT_EULER_TRANSFORM_MATRIX_MACROS_SVH

// assertion with reset disable
`define SETM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define SETM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/setm_pkg.sv
`default_nettype none

package setm_pkg;

   localparam int ANGLE_FRAC_BITS = 12;
   localparam int ANGLE_W = 16;
   localparam int ANGLE_SHIFT = 30 - ANGLE_FRAC_BITS;
   localparam int ZW = ANGLE_W + ANGLE_SHIFT + 1;
   localparam int XW = 33;
   localparam int RVW = 34;
   localparam int PW = 66;
   localparam int RW = 36;
   localparam int ATAN_LEN = 24;

   localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
   localparam logic signed [ZW-1:0] TWO_PI_Q30 = ZW'(64'sd6746518852);
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
   localparam logic signed [XW-1:0] GAIN_Q30 = XW'(64'sd652032874);

   typedef struct packed {
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } pass_type;

   function automatic logic signed [XW-1:0] atan_q30(input int unsigned i);
      logic signed [XW-1:0] v;
      case (i)
         0: v = XW'(32'sh3243F6A8);
         1: v = XW'(32'sh1DAC6705);
         2: v = XW'(32'sh0FADBAFC);
         3: v = XW'(32'sh07F56EA6);
         4: v = XW'(32'sh03FEAB76);
         5: v = XW'(32'sh01FFD55B);
         6: v = XW'(32'sh00FFFAAA);
         7: v = XW'(32'sh007FFF55);
         8: v = XW'(32'sh003FFFEA);
         9: v = XW'(32'sh001FFFFD);
         10: v = XW'(32'sh000FFFFF);
         11: v = XW'(32'sh0007FFFF);
         12: v = XW'(32'sh0003FFFF);
         13: v = XW'(32'sh0001FFFF);
         14: v = XW'(32'sh0000FFFF);
         15: v = XW'(32'sh00007FFF);
         16: v = XW'(32'sh00003FFF);
         17: v = XW'(32'sh00001FFF);
         18: v = XW'(32'sh00000FFF);
         19: v = XW'(32'sh000007FF);
         20: v = XW'(32'sh000003FF);
         21: v = XW'(32'sh000001FF);
         22: v = XW'(32'sh000000FF);
         23: v = XW'(32'sh0000007F);
         default: v = '0;
      endcase
      return v;
   endfunction

   // round a Q30 product back to Q30
   function automatic logic signed [RW-1:0] rnd30(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = p + PW'(64'sd536870912);
      return RW'(t >>> 30);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
      logic signed [31:0] r;
      if (v > RW'(64'sd2147483647)) begin
         r = 32'sh7FFFFFFF;
      end else if (v < RW'(-64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/srt_euler_transform_matrix.sv
// throughput: one request per cycle while rsp_stall is low;
// the CORDIC is unrolled into one stage per step
// each stage moves on when it is empty or its successor takes its contents
// reset: synchronous, clears the stage valid bits only; data registers are not reset
`default_nettype none

`include "srt_euler_transform_matrix_macros.svh"

module srt_euler_transform_matrix #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire setm_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output setm_pkg::rsp_type        rsp_data
);

   localparam int NSTEP = (CORDIC_STEPS < setm_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : setm_pkg::ATAN_LEN;
   localparam int NS = NSTEP + 9;
   localparam int SC = 2;
   localparam int S3 = NSTEP + 2;
   localparam int S4 = NSTEP + 3;
   localparam int S5 = NSTEP + 4;
   localparam int S6 = NSTEP + 5;
   localparam int S7 = NSTEP + 6;
   localparam int S8 = NSTEP + 7;
   localparam int S9 = NSTEP + 8;
   localparam int ZW = setm_pkg::ZW;
   localparam int XW = setm_pkg::XW;
   localparam int RVW = setm_pkg::RVW;
   localparam int PW = setm_pkg::PW;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;

   setm_pkg::pass_type pass_ff [NS-1];
   setm_pkg::pass_type pass_in;

   logic signed [15:0]   ang [3];
   logic signed [ZW-1:0] z1_ff [3];
   logic signed [ZW-1:0] z1_in [3];
   logic signed [XW-1:0] z2_ff [3];
   logic signed [XW-1:0] z2_in [3];
   logic                 n2_ff [3];
   logic                 n2_in [3];

   logic signed [XW-1:0] cx_ff [NSTEP][3];
   logic signed [XW-1:0] cy_ff [NSTEP][3];
   logic signed [XW-1:0] cz_ff [NSTEP][3];
   logic                 cn_ff [NSTEP][3];
   logic signed [XW-1:0] cx_in [NSTEP][3];
   logic signed [XW-1:0] cy_in [NSTEP][3];
   logic signed [XW-1:0] cz_in [NSTEP][3];
   logic                 cn_in [NSTEP][3];

   logic signed [XW-1:0] sn_ff [3];
   logic signed [XW-1:0] cs_ff [3];
   logic signed [XW-1:0] sn_in [3];
   logic signed [XW-1:0] cs_in [3];

   logic signed [PW-1:0] p1_ff [10];
   logic signed [PW-1:0] p1_in [10];
   logic signed [XW-1:0] k4_ff [3];
   logic signed [XW-1:0] r1_ff [10];
   logic signed [XW-1:0] k5_ff [3];
   logic signed [PW-1:0] p2_ff [4];
   logic signed [PW-1:0] p2_in [4];
   logic signed [XW-1:0] r1b_ff [10];
   logic signed [XW-1:0] sb6_ff;
   logic signed [RVW-1:0] rv_ff [9];
   logic signed [RVW-1:0] rv_in [9];
   logic signed [PW-1:0] mp_ff [9];
   logic signed [PW-1:0] mp_in [9];
   logic signed [31:0]   scl [3];
   setm_pkg::rsp_type    out_ff;
   setm_pkg::rsp_type    out_in;

   // stage enables
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (!en[k]) begin
            vld_in[k] = vld_ff[k];
         end else if (k == 0) begin
            vld_in[k] = req_valid;
         end else begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = out_ff;

   always_comb begin
      pass_in.scale_x = req_data.scale_x;
      pass_in.scale_y = req_data.scale_y;
      pass_in.scale_z = req_data.scale_z;
      pass_in.pos_x   = req_data.pos_x;
      pass_in.pos_y   = req_data.pos_y;
      pass_in.pos_z   = req_data.pos_z;
      ang[0] = req_data.angle_x;
      ang[1] = req_data.angle_y;
      ang[2] = req_data.angle_z;
   end

   // angle reduction into [-pi, pi], then fold into [-pi/2, pi/2]
   always_comb begin
      logic signed [ZW-1:0] w;
      for (int a = 0; a < 3; a++) begin
         w = ZW'(ang[a]) <<< setm_pkg::ANGLE_SHIFT;
         if (w > setm_pkg::PI_Q30) begin
            z1_in[a] = w - setm_pkg::TWO_PI_Q30;
         end else if (w < -setm_pkg::PI_Q30) begin
            z1_in[a] = w + setm_pkg::TWO_PI_Q30;
         end else begin
            z1_in[a] = w;
         end
         if (z1_ff[a] > setm_pkg::HALF_PI_Q30) begin
            z2_in[a] = XW'(z1_ff[a] - setm_pkg::PI_Q30);
            n2_in[a] = 1'b1;
         end else if (z1_ff[a] < -setm_pkg::HALF_PI_Q30) begin
            z2_in[a] = XW'(z1_ff[a] + setm_pkg::PI_Q30);
            n2_in[a] = 1'b1;
         end else begin
            z2_in[a] = XW'(z1_ff[a]);
            n2_in[a] = 1'b0;
         end
      end
   end

   // cordic rotation steps, one stage each
   always_comb begin
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [XW-1:0] z;
      logic                 n;
      for (int j = 0; j < NSTEP; j++) begin
         for (int a = 0; a < 3; a++) begin
            if (j == 0) begin
               x = setm_pkg::GAIN_Q30;
               y = '0;
               z = z2_ff[a];
               n = n2_ff[a];
            end else begin
               x = cx_ff[j-1][a];
               y = cy_ff[j-1][a];
               z = cz_ff[j-1][a];
               n = cn_ff[j-1][a];
            end
            if (!z[XW-1]) begin
               cx_in[j][a] = x - (y >>> j);
               cy_in[j][a] = y + (x >>> j);
               cz_in[j][a] = z - setm_pkg::atan_q30(j);
            end else begin
               cx_in[j][a] = x + (y >>> j);
               cy_in[j][a] = y - (x >>> j);
               cz_in[j][a] = z + setm_pkg::atan_q30(j);
            end
            cn_in[j][a] = n;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sn_in[a] = cn_ff[NSTEP-1][a] ? -cy_ff[NSTEP-1][a] : cy_ff[NSTEP-1][a];
         cs_in[a] = cn_ff[NSTEP-1][a] ? -cx_ff[NSTEP-1][a] : cx_ff[NSTEP-1][a];
      end
   end

   // first products: 0 sa*sb, 1 ca*sb, 2 cb*cg, 3 cb*sg, 4 sa*cb,
   // 5 ca*cb, 6 ca*sg, 7 ca*cg, 8 sa*sg, 9 sa*cg
   always_comb begin
      p1_in[0] = PW'(sn_ff[0]) * PW'(sn_ff[1]);
      p1_in[1] = PW'(cs_ff[0]) * PW'(sn_ff[1]);
      p1_in[2] = PW'(cs_ff[1]) * PW'(cs_ff[2]);
      p1_in[3] = PW'(cs_ff[1]) * PW'(sn_ff[2]);
      p1_in[4] = PW'(sn_ff[0]) * PW'(cs_ff[1]);
      p1_in[5] = PW'(cs_ff[0]) * PW'(cs_ff[1]);
      p1_in[6] = PW'(cs_ff[0]) * PW'(sn_ff[2]);
      p1_in[7] = PW'(cs_ff[0]) * PW'(cs_ff[2]);
      p1_in[8] = PW'(sn_ff[0]) * PW'(sn_ff[2]);
      p1_in[9] = PW'(sn_ff[0]) * PW'(cs_ff[2]);
   end

   // second products: sasb*cg, sasb*sg, casb*cg, casb*sg (k5: sb, sg, cg)
   always_comb begin
      p2_in[0] = PW'(r1_ff[0]) * PW'(k5_ff[2]);
      p2_in[1] = PW'(r1_ff[0]) * PW'(k5_ff[1]);
      p2_in[2] = PW'(r1_ff[1]) * PW'(k5_ff[2]);
      p2_in[3] = PW'(r1_ff[1]) * PW'(k5_ff[1]);
   end

   always_comb begin
      rv_in[0] = RVW'(r1b_ff[2]);
      rv_in[1] = RVW'(r1b_ff[3]);
      rv_in[2] = -RVW'(sb6_ff);
      rv_in[3] = RVW'(setm_pkg::rnd30(p2_ff[0])) - RVW'(r1b_ff[6]);
      rv_in[4] = RVW'(setm_pkg::rnd30(p2_ff[1])) + RVW'(r1b_ff[7]);
      rv_in[5] = RVW'(r1b_ff[4]);
      rv_in[6] = RVW'(setm_pkg::rnd30(p2_ff[2])) + RVW'(r1b_ff[8]);
      rv_in[7] = RVW'(setm_pkg::rnd30(p2_ff[3])) - RVW'(r1b_ff[9]);
      rv_in[8] = RVW'(r1b_ff[5]);
   end

   always_comb begin
      scl[0] = pass_ff[S7].scale_x;
      scl[1] = pass_ff[S7].scale_y;
      scl[2] = pass_ff[S7].scale_z;
      for (int e = 0; e < 9; e++) begin
         mp_in[e] = PW'(scl[e / 3]) * PW'(rv_ff[e]);
      end
   end

   always_comb begin
      out_in.m00 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[0]));
      out_in.m01 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[1]));
      out_in.m02 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[2]));
      out_in.m10 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[3]));
      out_in.m11 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[4]));
      out_in.m12 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[5]));
      out_in.m20 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[6]));
      out_in.m21 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[7]));
      out_in.m22 = setm_pkg::sat32(setm_pkg::rnd30(mp_ff[8]));
      out_in.tx  = pass_ff[S8].pos_x;
      out_in.ty  = pass_ff[S8].pos_y;
      out_in.tz  = pass_ff[S8].pos_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS - 1; k++) begin
         if (en[k]) begin
            pass_ff[k] <= (k == 0) ? pass_in : pass_ff[(k == 0) ? 0 : k - 1];
         end
      end
      if (en[0]) begin
         z1_ff <= z1_in;
      end
      if (en[1]) begin
         z2_ff <= z2_in;
         n2_ff <= n2_in;
      end
      for (int j = 0; j < NSTEP; j++) begin
         if (en[SC + j]) begin
            cx_ff[j] <= cx_in[j];
            cy_ff[j] <= cy_in[j];
            cz_ff[j] <= cz_in[j];
            cn_ff[j] <= cn_in[j];
         end
      end
      if (en[S3]) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
      if (en[S4]) begin
         p1_ff <= p1_in;
         k4_ff[0] <= sn_ff[1];
         k4_ff[1] <= sn_ff[2];
         k4_ff[2] <= cs_ff[2];
      end
      if (en[S5]) begin
         for (int i = 0; i < 10; i++) begin
            r1_ff[i] <= XW'(setm_pkg::rnd30(p1_ff[i]));
         end
         k5_ff <= k4_ff;
      end
      if (en[S6]) begin
         p2_ff  <= p2_in;
         r1b_ff <= r1_ff;
         sb6_ff <= k5_ff[0];
      end
      if (en[S7]) begin
         rv_ff <= rv_in;
      end
      if (en[S8]) begin
         mp_ff <= mp_in;
      end
      if (en[S9]) begin
         out_ff <= out_in;
      end
   end

   `SETM_ASSERT(a_stall_full, clock, reset, req_stall |-> vld_ff[0], "input stalled with first stage empty")
   `SETM_ASSERT(a_take, clock, reset, req_valid && !req_stall |=> vld_ff[0], "accepted request lost")
   `SETM_ASSERT(a_hold, clock, reset, vld_ff[S8] && !en[S8] |=> vld_ff[S8], "held stage dropped its request")
   `SETM_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

### bench/srt_euler_checker.sv
`timescale 1ns / 1ps

module srt_euler_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire setm_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire setm_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     matrix_count
);

   localparam int STEPS = 16;
   localparam longint PI_C = 64'sd3373259426;
   localparam longint HALF_PI_C = 64'sd1686629713;

   setm_pkg::rsp_type expected_matrices[$];

   function automatic longint atan_entry(input int i);
      longint t[24];
      t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      return t[i];
   endfunction

   function automatic longint round_q30(input longint p);
      return (p + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [31:0] clamp_entry(input longint sc, input longint r);
      longint v;
      v = round_q30(sc * r);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

   function automatic void sine_cosine(input logic signed [15:0] ang, output longint s,
                                       output longint c);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) * 64'sd262144;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      while (z > PI_C) z -= 2 * PI_C;
      while (z < -PI_C) z += 2 * PI_C;
      if (z > HALF_PI_C) begin
         z -= PI_C;
         flip = 1;
      end else if (z < -HALF_PI_C) begin
         z += PI_C;
         flip = 1;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_entry(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_entry(i);
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic setm_pkg::rsp_type transform_matrix(input setm_pkg::req_type r);
      setm_pkg::rsp_type m;
      longint sa, ca, sb, cb, sg, cg, sasb, casb, kx, ky, kz;
      sine_cosine(r.angle_x, sa, ca);
      sine_cosine(r.angle_y, sb, cb);
      sine_cosine(r.angle_z, sg, cg);
      kx = r.scale_x;
      ky = r.scale_y;
      kz = r.scale_z;
      sasb = round_q30(sa * sb);
      casb = round_q30(ca * sb);
      m.m00 = clamp_entry(kx, round_q30(cb * cg));
      m.m01 = clamp_entry(kx, round_q30(cb * sg));
      m.m02 = clamp_entry(kx, -sb);
      m.m10 = clamp_entry(ky, round_q30(sasb * cg) - round_q30(ca * sg));
      m.m11 = clamp_entry(ky, round_q30(sasb * sg) + round_q30(ca * cg));
      m.m12 = clamp_entry(ky, round_q30(sa * cb));
      m.m20 = clamp_entry(kz, round_q30(casb * cg) + round_q30(sa * sg));
      m.m21 = clamp_entry(kz, round_q30(casb * sg) - round_q30(sa * cg));
      m.m22 = clamp_entry(kz, round_q30(ca * cb));
      m.tx = r.pos_x;
      m.ty = r.pos_y;
      m.tz = r.pos_z;
      return m;
   endfunction

   initial begin
      fail_count = 0;
      matrix_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      setm_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_matrices.push_back(transform_matrix(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            matrix_count++;
            if (expected_matrices.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected matrix %h", rsp_data);
            end else begin
               want = expected_matrices.pop_front();
               if (want !== rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at matrix %0d", matrix_count);
                     $display("  exp %h", want);
                     $display("  got %h", rsp_data);
                  end
               end
            end
         end
      end
      pending_count = expected_matrices.size();
   end
endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int NUM_RANDOM = 1700;
   localparam int WATCHDOG = 20000;

   logic clock, reset, req_valid, rsp_stall, req_stall, rsp_valid;
   setm_pkg::req_type req_data;
   setm_pkg::rsp_type rsp_data;
   int fail_count, pending_count, matrix_count, idle_cycles, sent, stall_left;
   bit stall_free;

   srt_euler_transform_matrix uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   srt_euler_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .matrix_count(matrix_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(9) < 8) return $urandom_range(2);
      return $urandom_range(30);
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00010000;
         3: return 32'hFFFF0000;
         4: return 32'(signed'($urandom_range(2_000_000)) - 1_000_000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(signed'($urandom_range(12868)) - 6434);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic setm_pkg::req_type random_request();
      setm_pkg::req_type r;
      r.scale_x = pick32(); r.scale_y = pick32(); r.scale_z = pick32();
      r.angle_x = pick16(); r.angle_y = pick16(); r.angle_z = pick16();
      r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
      return r;
   endfunction

   function automatic setm_pkg::req_type make_request(input logic [31:0] sc,
                                                      input logic [15:0] ax,
                                                      input logic [15:0] ay,
                                                      input logic [15:0] az);
      setm_pkg::req_type r;
      r.scale_x = sc; r.scale_y = sc; r.scale_z = sc;
      r.angle_x = ax; r.angle_y = ay; r.angle_z = az;
      r.pos_x = ~sc; r.pos_y = sc; r.pos_z = {ax, az};
      return r;
   endfunction

   task automatic send(input setm_pkg::req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // randomized result-side backpressure, with a stall-free stretch
   always @(posedge clock) begin
      if (reset || stall_free) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(9) < 3) begin
         rsp_stall <= 1;
         stall_left <= gap_len();
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog: no traffic for %0d cycles", WATCHDOG);
         $display("** srt_euler_transform_matrix: FAILED **");
         $finish;
      end
   end

   initial begin
      setm_pkg::req_type dir[$];
      reset = 1; req_valid = 0; rsp_stall = 0; req_data = '0; stall_free = 0;
      sent = 0; idle_cycles = 0; stall_left = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      // extremes, quadrant folds, wraps past pi, saturation
      dir.push_back(make_request(32'h00010000, 16'h0000, 16'h0000, 16'h0000));
      dir.push_back(make_request(32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      dir.push_back(make_request(32'h80000000, 16'h8000, 16'h8000, 16'h8000));
      dir.push_back(make_request(32'h7FFFFFFF, 16'h1922, 16'h1921, 16'hE6DF));
      dir.push_back(make_request(32'h80000000, 16'h3244, 16'hCDBC, 16'h3243));
      dir.push_back(make_request(32'hFFFFFFFF, 16'h6488, 16'h9B78, 16'h0001));
      dir.push_back(make_request(32'h00000000, 16'hFFFF, 16'h4000, 16'hC000));
      dir.push_back(make_request(32'hFFFF0000, 16'h0C91, 16'h2000, 16'hF36F));
      dir.push_back(make_request(32'h00000001, 16'h3245, 16'h6487, 16'h9B79));
      dir.push_back(make_request(32'h55555555, 16'hAAAA, 16'h5555, 16'h1234));
      dir.push_back(make_request(32'hAAAAAAAA, 16'h5555, 16'hAAAA, 16'hEDCB));
      foreach (dir[i]) send(dir[i]);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         stall_free = (i >= 600 && i < 800);
         send(random_request());
      end
      req_valid <= 0;
      stall_free = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d transform requests (%0d directed), checked %0d matrices",
               sent, dir.size(), matrix_count);
      $display("covered angle extremes, quadrant folding, scale saturation, backpressure");
      if (fail_count == 0 && pending_count == 0) begin
         $display("** srt_euler_transform_matrix: PASSED **");
      end else begin
         $display("** srt_euler_transform_matrix: FAILED **");
      end
      $finish;
   end
endmodule

### srt_euler_transform_matrix.f
+incdir+rtl
rtl/setm_pkg.sv
rtl/srt_euler_transform_matrix.sv
bench/srt_euler_checker.sv
bench/tb.sv
